// ----- sv/ubil_pkg.sv -----
package ubil_pkg;

  localparam int unsigned MaxRes   = 3;
  localparam int unsigned QueueDep = 2;

  localparam logic [7:0] ByteStart = 8'h02;
  localparam logic [7:0] ByteHello = 8'h01;
  localparam logic [7:0] ByteAck   = 8'h06;
  localparam logic [7:0] ByteD     = 8'h44;

  localparam logic [15:0] ResetImageLen   = 16'd0;
  localparam logic [15:0] ResetFirstTmo   = 16'd614;
  localparam logic [15:0] ResetCharTmo    = 16'd102;
  localparam logic [2:0]  ResetMaxAttempt = 3'd3;
  localparam logic [5:0]  ResetIdLimit    = 6'd32;

  typedef enum logic [2:0] {
    CfgImageLen  = 3'd0,
    CfgFirstTmo  = 3'd1,
    CfgCharTmo   = 3'd2,
    CfgMaxAttmpt = 3'd3,
    CfgIdLimit   = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PhIdle   = 3'd0,
    PhSearch = 3'd1,
    PhHeader = 3'd2,
    PhSend   = 3'd3,
    PhCheck  = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    ActStart  = 3'd0,
    ActTick   = 3'd1,
    ActRxByte = 3'd2,
    ActRxErr  = 3'd3,
    ActImage  = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    KindTx      = 2'd0,
    KindRestart = 2'd1,
    KindOk      = 2'd2,
    KindFail    = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ErrNone     = 3'd0,
    ErrTimeout  = 3'd1,
    ErrUart     = 3'd2,
    ErrNoStart  = 3'd3,
    ErrHeader   = 3'd4,
    ErrMismatch = 3'd5
  } err_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] tx_byte;
    logic [2:0] error_code;
    logic [2:0] attempt;
  } result_t;

  typedef struct packed {
    logic [1:0]                cnt;
    result_t [MaxRes-1:0]      res;
  } bundle_t;

endpackage

// ----- sv/uart_boot_image_loader.sv -----
// channel   | handshake                 | payload
// ----------+---------------------------+------------------------------------------
// input     | in_valid_i / in_stall_o   | action_i, byte_value_i, framing_only_i
// result    | out_valid_o / out_stall_i | kind_o, tx_byte_o, error_code_o,
//           |                           | attempt_o, last_o
// config    | cfg_we_i                  | cfg_idx_i, cfg_data_i
//
// an item enters the input register, is stepped through the download state
// machine once the queue has room and its zero to three results go into a
// two-entry queue; one item per cycle while each gives at most one result and
// the output is not stalled, an item with several results gives them in turn
// asynchronous active-low reset clears control state and loads register defaults
// a stalled output backs up into the queue, then into the input register
module uart_boot_image_loader (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input items
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  action_i,
  input  logic [7:0]  byte_value_i,
  input  logic        framing_only_i,
  // result items
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  tx_byte_o,
  output logic [2:0]  error_code_o,
  output logic [2:0]  attempt_o,
  output logic        last_o,
  // register writes
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);
  import ubil_pkg::*;

  bundle_t bundle;
  logic    push;
  logic    push_ok;
  result_t res;

  // download sequencer with its input register and register file
  ubil_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .byte_value_i   (byte_value_i),
    .framing_only_i (framing_only_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .push_ok_i      (push_ok),
    .push_o         (push),
    .bundle_o       (bundle)
  );

  // result queue, unpacks each bundle one item at a time
  ubil_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .bundle_i    (bundle),
    .push_ok_o   (push_ok),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res),
    .last_o      (last_o)
  );

  assign kind_o       = res.kind;
  assign tx_byte_o    = res.tx_byte;
  assign error_code_o = res.error_code;
  assign attempt_o    = res.attempt;

endmodule

// ----- sv/ubil_core.sv -----
module ubil_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [2:0]      action_i,
  input  logic [7:0]      byte_value_i,
  input  logic            framing_only_i,
  input  logic            cfg_we_i,
  input  logic [2:0]      cfg_idx_i,
  input  logic [15:0]     cfg_data_i,
  input  logic            push_ok_i,
  output logic            push_o,
  output ubil_pkg::bundle_t bundle_o
);
  import ubil_pkg::*;

  // config registers
  logic [15:0] img_len_q, first_tmo_q, char_tmo_q;
  logic [2:0]  max_att_q;
  logic [5:0]  id_lim_q;

  // input register
  logic        in_vld_q;
  logic [2:0]  act_q;
  logic [7:0]  byte_q;
  logic        frm_q;

  // protocol state
  phase_e      phase_q, phase_d;
  logic [2:0]  att_q, att_d;
  logic [5:0]  sc_q, sc_d;
  logic [15:0] tmr_q, tmr_d;
  logic        short_q, short_d;
  logic [15:0] bs_q, bs_d;
  logic [7:0]  chk_q, chk_d;

  logic        proc;
  logic        in_take;
  logic        waiting;
  logic        do_fail;
  err_e        fail_err;
  logic [15:0] tmo_lim;
  logic [5:0]  sc_inc;
  logic [5:0]  id_lim_eff;
  logic [2:0]  att_lim;
  logic [15:0] bs_inc;
  bundle_t     bnd;

  assign proc       = in_vld_q & push_ok_i;
  assign in_stall_o = in_vld_q & ~push_ok_i;
  assign in_take    = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_len_q   <= ResetImageLen;
      first_tmo_q <= ResetFirstTmo;
      char_tmo_q  <= ResetCharTmo;
      max_att_q   <= ResetMaxAttempt;
      id_lim_q    <= ResetIdLimit;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgImageLen:  img_len_q   <= cfg_data_i;
        CfgFirstTmo:  first_tmo_q <= cfg_data_i;
        CfgCharTmo:   char_tmo_q  <= cfg_data_i;
        CfgMaxAttmpt: max_att_q   <= cfg_data_i[2:0];
        CfgIdLimit:   id_lim_q    <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (proc) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      act_q  <= action_i;
      byte_q <= byte_value_i;
      frm_q  <= framing_only_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      att_q   <= '0;
      sc_q    <= '0;
      tmr_q   <= '0;
      short_q <= 1'b0;
      bs_q    <= '0;
      chk_q   <= '0;
    end else if (proc) begin
      phase_q <= phase_d;
      att_q   <= att_d;
      sc_q    <= sc_d;
      tmr_q   <= tmr_d;
      short_q <= short_d;
      bs_q    <= bs_d;
      chk_q   <= chk_d;
    end
  end

  assign waiting    = (phase_q == PhSearch) || (phase_q == PhHeader) || (phase_q == PhCheck);
  assign tmo_lim    = (phase_q == PhSearch && !short_q) ? first_tmo_q : char_tmo_q;
  assign sc_inc     = 6'(sc_q + 6'd1);
  assign id_lim_eff = (id_lim_q == '0) ? 6'd1 : id_lim_q;
  assign att_lim    = (max_att_q == '0) ? 3'd1 : max_att_q;
  assign bs_inc     = 16'(bs_q + 16'd1);

  always_comb begin
    phase_d  = phase_q;
    att_d    = att_q;
    sc_d     = sc_q;
    tmr_d    = tmr_q;
    short_d  = short_q;
    bs_d     = bs_q;
    chk_d    = chk_q;
    do_fail  = 1'b0;
    fail_err = ErrNone;
    bnd      = '0;

    unique case (act_q)
      ActStart: begin
        att_d   = 3'd1;
        phase_d = PhSearch;
        sc_d    = '0;
        tmr_d   = '0;
        short_d = 1'b0;
        bs_d    = '0;
        chk_d   = '0;
        bnd.cnt = 2'd1;
        bnd.res[0] = '{kind: KindRestart, tx_byte: 8'h00, error_code: ErrNone,
                       attempt: 3'd1};
      end
      ActTick: begin
        if (waiting) begin
          if (tmr_q >= tmo_lim) begin
            do_fail  = 1'b1;
            fail_err = ErrTimeout;
          end else begin
            tmr_d = 16'(tmr_q + 16'd1);
          end
        end
      end
      ActRxByte: begin
        unique case (phase_q)
          PhSearch: begin
            tmr_d = '0;
            if (byte_q == ByteStart) begin
              phase_d = PhHeader;
              bnd.cnt = 2'd3;
              bnd.res[0] = '{kind: KindTx, tx_byte: ByteHello, error_code: ErrNone,
                             attempt: att_q};
              bnd.res[1] = '{kind: KindTx, tx_byte: img_len_q[7:0], error_code: ErrNone,
                             attempt: att_q};
              bnd.res[2] = '{kind: KindTx, tx_byte: img_len_q[15:8], error_code: ErrNone,
                             attempt: att_q};
            end else begin
              if (byte_q == ByteD) short_d = 1'b1;
              sc_d = sc_inc;
              if (sc_inc >= id_lim_eff) begin
                do_fail  = 1'b1;
                fail_err = ErrNoStart;
              end
            end
          end
          PhHeader: begin
            tmr_d = '0;
            if (byte_q == ByteAck) begin
              bs_d    = '0;
              chk_d   = '0;
              phase_d = (img_len_q == '0) ? PhCheck : PhSend;
            end else begin
              do_fail  = 1'b1;
              fail_err = ErrHeader;
            end
          end
          PhCheck: begin
            tmr_d = '0;
            if (byte_q == chk_q) begin
              phase_d = PhIdle;
              bnd.cnt = 2'd2;
              bnd.res[0] = '{kind: KindTx, tx_byte: ByteAck, error_code: ErrNone,
                             attempt: att_q};
              bnd.res[1] = '{kind: KindOk, tx_byte: 8'h00, error_code: ErrNone,
                             attempt: att_q};
            end else begin
              do_fail  = 1'b1;
              fail_err = ErrMismatch;
            end
          end
          default: ;
        endcase
      end
      ActRxErr: begin
        if (waiting && !frm_q) begin
          do_fail  = 1'b1;
          fail_err = ErrUart;
        end
      end
      ActImage: begin
        if (phase_q == PhSend) begin
          chk_d   = chk_q ^ byte_q;
          bs_d    = bs_inc;
          bnd.cnt = 2'd1;
          bnd.res[0] = '{kind: KindTx, tx_byte: byte_q, error_code: ErrNone,
                         attempt: att_q};
          if (bs_inc >= img_len_q) begin
            phase_d = PhCheck;
            tmr_d   = '0;
          end
        end
      end
      default: ;
    endcase

    // a failure is always the only result of its item
    if (do_fail) begin
      bnd.cnt = 2'd1;
      if (att_q < att_lim) begin
        att_d   = 3'(att_q + 3'd1);
        phase_d = PhSearch;
        sc_d    = '0;
        tmr_d   = '0;
        short_d = 1'b0;
        bs_d    = '0;
        chk_d   = '0;
        bnd.res[0] = '{kind: KindRestart, tx_byte: 8'h00, error_code: fail_err,
                       attempt: att_d};
      end else begin
        phase_d = PhIdle;
        bnd.res[0] = '{kind: KindFail, tx_byte: 8'h00, error_code: fail_err,
                       attempt: att_q};
      end
    end
  end

  assign push_o   = proc & (bnd.cnt != 2'd0);
  assign bundle_o = bnd;

endmodule

// ----- sv/ubil_outq.sv -----
module ubil_outq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ubil_pkg::bundle_t bundle_i,
  output logic              push_ok_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ubil_pkg::result_t res_o,
  output logic              last_o
);
  import ubil_pkg::*;

  bundle_t    q_q [QueueDep];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic [1:0] idx_q;
  bundle_t    head;
  logic       take;
  logic       pop;

  assign head        = q_q[rd_ptr_q];
  assign out_valid_o = cnt_q != 2'd0;
  assign res_o       = head.res[idx_q];
  assign last_o      = idx_q == 2'(head.cnt - 2'd1);
  assign take        = out_valid_o & ~out_stall_i;
  assign pop         = take & last_o;
  assign push_ok_o   = cnt_q != 2'(QueueDep);

  always_ff @(posedge clk_i) begin
    if (push_i) q_q[wr_ptr_q] <= bundle_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
      idx_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
        idx_q    <= '0;
      end else if (take) begin
        idx_q <= 2'(idx_q + 2'd1);
      end
      unique case ({push_i, pop})
        2'b10:   cnt_q <= 2'(cnt_q + 2'd1);
        2'b01:   cnt_q <= 2'(cnt_q - 2'd1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ----- tb/ubil_download_checker.sv -----
`timescale 1ns / 1ps

module ubil_download_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [2:0]  action_i,
  input  logic [7:0]  byte_value_i,
  input  logic        framing_only_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  tx_byte_i,
  input  logic [2:0]  error_code_i,
  input  logic [2:0]  attempt_i,
  input  logic        last_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  output int unsigned fail_count_o,
  output int unsigned backlog_o
);
  import ubil_pkg::*;

  typedef struct {
    kind_e      kind;
    logic [7:0] tx_byte;
    err_e       err;
    logic [2:0] attempt;
    logic       fin;
  } host_event_t;

  // register copy
  logic [15:0] img_len;
  logic [15:0] first_tmo;
  logic [15:0] char_tmo;
  logic [2:0]  max_tries;
  logic [5:0]  id_limit;

  // download state
  phase_e      ph;
  logic [2:0]  tries;
  logic [5:0]  id_seen;
  logic [15:0] tick_cnt;
  logic        short_tmo;
  logic [15:0] sent;
  logic [7:0]  xor_acc;

  host_event_t batch[$];
  host_event_t due_events[$];
  int unsigned fails = 0;

  assign fail_count_o = fails;

  task automatic flag_error(string what);
    fails++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  function automatic void add_event(kind_e k, logic [7:0] b, err_e e);
    host_event_t ev;
    ev.kind    = k;
    ev.tx_byte = b;
    ev.err     = e;
    ev.attempt = tries;
    ev.fin     = 1'b0;
    batch.push_back(ev);
  endfunction

  function automatic void begin_search();
    ph        = PhSearch;
    id_seen   = '0;
    tick_cnt  = '0;
    short_tmo = 1'b0;
    sent      = '0;
    xor_acc   = '0;
  endfunction

  // retry with a fresh reset pulse or give up
  function automatic void lose_attempt(err_e e);
    logic [2:0] lim;
    lim = (max_tries == 3'd0) ? 3'd1 : max_tries;
    if (tries < lim) begin
      tries = tries + 3'd1;
      begin_search();
      add_event(KindRestart, 8'h00, e);
    end else begin
      ph = PhIdle;
      add_event(KindFail, 8'h00, e);
    end
  endfunction

  function automatic void host_step(logic [2:0] act, logic [7:0] b, logic framing);
    logic        waiting;
    logic [15:0] lim;
    logic [5:0]  id_lim;
    waiting = (ph == PhSearch) || (ph == PhHeader) || (ph == PhCheck);
    batch.delete();
    case (act)
      ActStart: begin
        tries = 3'd1;
        begin_search();
        add_event(KindRestart, 8'h00, ErrNone);
      end
      ActTick: begin
        if (waiting) begin
          lim = (ph == PhSearch && !short_tmo) ? first_tmo : char_tmo;
          if (tick_cnt >= lim) lose_attempt(ErrTimeout);
          else tick_cnt = tick_cnt + 16'd1;
        end
      end
      ActRxByte: begin
        if (ph == PhSearch) begin
          tick_cnt = '0;
          if (b == ByteStart) begin
            ph = PhHeader;
            add_event(KindTx, ByteHello, ErrNone);
            add_event(KindTx, img_len[7:0], ErrNone);
            add_event(KindTx, img_len[15:8], ErrNone);
          end else begin
            id_lim = (id_limit == 6'd0) ? 6'd1 : id_limit;
            if (b == ByteD) short_tmo = 1'b1;
            id_seen = id_seen + 6'd1;
            if (id_seen >= id_lim) lose_attempt(ErrNoStart);
          end
        end else if (ph == PhHeader) begin
          tick_cnt = '0;
          if (b == ByteAck) begin
            sent    = '0;
            xor_acc = '0;
            ph      = (img_len == 16'd0) ? PhCheck : PhSend;
          end else begin
            lose_attempt(ErrHeader);
          end
        end else if (ph == PhCheck) begin
          tick_cnt = '0;
          if (b == xor_acc) begin
            ph = PhIdle;
            add_event(KindTx, ByteAck, ErrNone);
            add_event(KindOk, 8'h00, ErrNone);
          end else begin
            lose_attempt(ErrMismatch);
          end
        end
      end
      ActRxErr: begin
        if (waiting && !framing) lose_attempt(ErrUart);
      end
      ActImage: begin
        if (ph == PhSend) begin
          xor_acc = xor_acc ^ b;
          add_event(KindTx, b, ErrNone);
          sent = sent + 16'd1;
          if (sent >= img_len) begin
            ph       = PhCheck;
            tick_cnt = '0;
          end
        end
      end
      default: ;
    endcase
    if (batch.size() > 0) batch[batch.size() - 1].fin = 1'b1;
    foreach (batch[i]) due_events.push_back(batch[i]);
  endfunction

  task automatic check_result();
    host_event_t want;
    if (due_events.size() == 0) begin
      flag_error($sformatf("result with nothing due: kind %0d tx %02h code %0d attempt %0d",
                           kind_i, tx_byte_i, error_code_i, attempt_i));
      return;
    end
    want = due_events.pop_front();
    if (kind_i !== want.kind || tx_byte_i !== want.tx_byte || error_code_i !== want.err ||
        attempt_i !== want.attempt || last_i !== want.fin) begin
      flag_error($sformatf({"got kind %0d tx %02h code %0d attempt %0d last %0b, ",
                            "want %0d %02h %0d %0d %0b"},
                           kind_i, tx_byte_i, error_code_i, attempt_i, last_i,
                           want.kind, want.tx_byte, want.err, want.attempt, want.fin));
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      img_len   = ResetImageLen;
      first_tmo = ResetFirstTmo;
      char_tmo  = ResetCharTmo;
      max_tries = ResetMaxAttempt;
      id_limit  = ResetIdLimit;
      begin_search();
      ph    = PhIdle;
      tries = '0;
      due_events.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgImageLen:  img_len   = cfg_data_i;
          CfgFirstTmo:  first_tmo = cfg_data_i;
          CfgCharTmo:   char_tmo  = cfg_data_i;
          CfgMaxAttmpt: max_tries = cfg_data_i[2:0];
          CfgIdLimit:   id_limit  = cfg_data_i[5:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) host_step(action_i, byte_value_i, framing_only_i);
      if (out_valid_i && !out_stall_i) check_result();
    end
    backlog_o <= due_events.size();
  end

endmodule

// ----- tb/uart_boot_image_loader_test.sv -----
`timescale 1ns / 1ps

module uart_boot_image_loader_test;
  import ubil_pkg::*;

  // action codes the block does not define, it must ignore them
  localparam logic [2:0] ActSpareLo = 3'd5;
  localparam logic [2:0] ActSpareHi = 3'd7;

  // where in an attempt a deliberate fault goes
  typedef enum int {
    FaultNone,
    FaultSearch,
    FaultHeader,
    FaultCheck
  } fault_at_e;

  logic        clk_i;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        in_stall_o;
  logic [2:0]  action_i       = ActStart;
  logic [7:0]  byte_value_i   = '0;
  logic        framing_only_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i    = 1'b0;
  logic [1:0]  kind_o;
  logic [7:0]  tx_byte_o;
  logic [2:0]  error_code_o;
  logic [2:0]  attempt_o;
  logic        last_o;
  logic        cfg_we_i       = 1'b0;
  logic [2:0]  cfg_idx_i      = CfgImageLen;
  logic [15:0] cfg_data_i     = '0;

  int unsigned fail_count;
  int unsigned backlog;

  // stimulus-side copy of the registers, only used to shape sequences
  int unsigned cur_len   = 32'(ResetImageLen);
  int unsigned cur_first = 32'(ResetFirstTmo);
  int unsigned cur_char  = 32'(ResetCharTmo);
  int unsigned cur_tries = 32'(ResetMaxAttempt);
  int unsigned cur_idlim = 32'(ResetIdLimit);

  // random idling on both sides, and the receiver hold-off request
  bit          jitter_on  = 1'b1;
  int unsigned hold_asks  = 0;
  int unsigned hold_done  = 0;
  int unsigned item_total = 0;

  uart_boot_image_loader i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .byte_value_i   (byte_value_i),
    .framing_only_i (framing_only_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .tx_byte_o      (tx_byte_o),
    .error_code_o   (error_code_o),
    .attempt_o      (attempt_o),
    .last_o         (last_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  ubil_download_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .action_i       (action_i),
    .byte_value_i   (byte_value_i),
    .framing_only_i (framing_only_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_i         (kind_o),
    .tx_byte_i      (tx_byte_o),
    .error_code_i   (error_code_o),
    .attempt_i      (attempt_o),
    .last_i         (last_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .fail_count_o   (fail_count),
    .backlog_o      (backlog)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // hard stop, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  // result side: random stalls, or one long hold-off when asked, so that the
  // result queue and then the input register fill up behind it
  initial begin
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_asks != hold_done) begin
        hold_done = hold_asks;
        out_stall_i <= 1'b1;
        repeat (80) @(posedge clk_i);
      end else begin
        out_stall_i <= jitter_on && ($urandom_range(0, 99) < 31);
        @(posedge clk_i);
      end
    end
  end

  // offer one item and hold it until taken; gaps go in front of it
  task automatic offer_item(logic [2:0] a, logic [7:0] b, logic f);
    while (jitter_on && $urandom_range(0, 99) < 31) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    action_i       <= a;
    byte_value_i   <= b;
    framing_only_i <= f;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    item_total++;
  endtask

  // stop offering, let every due result drain, then allow for items still
  // in flight that give no result
  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (backlog != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic put_reg(cfg_idx_e idx, logic [15:0] v);
    cfg_idx_i  <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
  endtask

  // write every register back to back while the block is quiet
  task automatic load_registers(int unsigned len, int unsigned first, int unsigned chr,
                                int unsigned tries, int unsigned idlim);
    wait_quiet();
    cfg_we_i <= 1'b1;
    put_reg(CfgImageLen, 16'(len));
    put_reg(CfgFirstTmo, 16'(first));
    put_reg(CfgCharTmo, 16'(chr));
    put_reg(CfgMaxAttmpt, 16'(tries));
    put_reg(CfgIdLimit, 16'(idlim));
    cfg_we_i  <= 1'b0;
    cur_len   = len;
    cur_first = first;
    cur_char  = chr;
    cur_tries = tries;
    cur_idlim = idlim;
  endtask

  // a chip-id byte that is never the start byte, often a 'D'
  function automatic logic [7:0] chip_byte();
    logic [7:0] b;
    b = ByteStart;
    if ($urandom_range(0, 3) == 0) return ByteD;
    while (b == ByteStart) b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  // a few ticks and framing-only errors that never reach the timeout
  task automatic harmless_waits(int unsigned lim);
    int unsigned k;
    if ($urandom_range(0, 99) < 60) return;
    k = $urandom_range(0, (lim < 3) ? lim : 3);
    repeat (k) offer_item(ActTick, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    if ($urandom_range(0, 3) == 0) offer_item(ActRxErr, 8'($urandom_range(0, 255)), 1'b1);
  endtask

  // make the current attempt go wrong; the wait timer is known to be zero
  task automatic break_attempt(fault_at_e where, logic [7:0] chk, int unsigned lim);
    int unsigned sel;
    sel = $urandom_range(0, 2);
    if (sel == 0 && lim > 40) sel = 1;
    if (sel == 0) begin
      repeat (lim + 1)
        offer_item(ActTick, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end else if (sel == 1) begin
      offer_item(ActRxErr, 8'($urandom_range(0, 255)), 1'b0);
    end else begin
      case (where)
        FaultSearch: begin
          // enough chip-id bytes to run past the search limit
          repeat (cur_idlim) offer_item(ActRxByte, chip_byte(), 1'($urandom_range(0, 1)));
        end
        FaultHeader: offer_item(ActRxByte, 8'(ByteAck ^ $urandom_range(1, 255)), 1'b0);
        default:     offer_item(ActRxByte, 8'(chk ^ $urandom_range(1, 255)), 1'b0);
      endcase
    end
  endtask

  // one attempt as the chip would answer it, with an optional fault
  task automatic run_attempt(fault_at_e where);
    logic [7:0]  chk;
    logic [7:0]  b;
    logic [2:0]  act;
    bit          d_seen;
    int unsigned n_id;
    chk    = '0;
    d_seen = 1'b0;
    n_id   = $urandom_range(0, (cur_idlim - 1 < 4) ? cur_idlim - 1 : 4);
    repeat (n_id) begin
      harmless_waits(d_seen ? cur_char : cur_first);
      b = chip_byte();
      if (b == ByteD) d_seen = 1'b1;
      offer_item(ActRxByte, b, 1'($urandom_range(0, 1)));
    end
    if (where == FaultSearch) begin
      break_attempt(where, chk, d_seen ? cur_char : cur_first);
      return;
    end
    harmless_waits(d_seen ? cur_char : cur_first);
    offer_item(ActRxByte, ByteStart, 1'($urandom_range(0, 1)));
    if (where == FaultHeader) begin
      break_attempt(where, chk, cur_char);
      return;
    end
    harmless_waits(cur_char);
    offer_item(ActRxByte, ByteAck, 1'($urandom_range(0, 1)));
    for (int i = 0; i < cur_len; i++) begin
      // stray traffic while image bytes flow is ignored by the block
      if ($urandom_range(0, 9) == 0) begin
        act = 3'($urandom_range(0, 7));
        if (act == ActStart || act == ActImage) act = ActTick;
        offer_item(act, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
      b   = 8'($urandom_range(0, 255));
      chk = chk ^ b;
      offer_item(ActImage, b, 1'($urandom_range(0, 1)));
    end
    if (where == FaultCheck) begin
      break_attempt(where, chk, cur_char);
      return;
    end
    harmless_waits(cur_char);
    offer_item(ActRxByte, chk, 1'($urandom_range(0, 1)));
  endtask

  // start, then attempts until one goes through or they run out
  task automatic run_download();
    fault_at_e where;
    offer_item(ActStart, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    for (int a = 0; a < cur_tries; a++) begin
      where = ($urandom_range(0, 99) < 25) ? fault_at_e'($urandom_range(1, 3)) : FaultNone;
      run_attempt(where);
      if (where == FaultNone) break;
    end
  endtask

  // unstructured items over every action code and field bit
  task automatic stray_items();
    repeat ($urandom_range(4, 12)) begin
      offer_item(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    int unsigned phase_no;
    int unsigned phase_base;
    int unsigned rand_base;
    int unsigned spins;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset register values: empty image, long first timeout
    // events while idle and unknown actions give nothing
    offer_item(ActTick, 8'h00, 1'b0);
    offer_item(ActRxByte, 8'hFF, 1'b1);
    offer_item(ActRxErr, 8'h00, 1'b0);
    offer_item(ActImage, 8'hAA, 1'b0);
    offer_item(ActSpareLo, 8'h55, 1'b1);
    offer_item(ActSpareHi, 8'hFF, 1'b0);
    // clean download of an empty image, check byte zero
    offer_item(ActStart, 8'h00, 1'b0);
    offer_item(ActRxByte, ByteD, 1'b0);
    offer_item(ActRxByte, 8'h00, 1'b0);
    offer_item(ActRxErr, 8'h00, 1'b1);
    offer_item(ActTick, 8'h00, 1'b0);
    offer_item(ActRxByte, ByteStart, 1'b0);
    offer_item(ActRxByte, ByteAck, 1'b0);
    offer_item(ActRxByte, 8'h00, 1'b0);
    // start while busy, uart error, header rejected, then out of attempts
    offer_item(ActStart, 8'hFF, 1'b1);
    offer_item(ActStart, 8'h00, 1'b0);
    offer_item(ActRxErr, 8'hFF, 1'b0);
    offer_item(ActRxByte, ByteStart, 1'b0);
    offer_item(ActRxByte, 8'h55, 1'b0);
    offer_item(ActRxErr, 8'h00, 1'b0);

    // extreme registers: zero timeouts, search limit of one, seven attempts
    load_registers(65534, 0, 0, 7, 1);
    offer_item(ActStart, 8'h00, 1'b0);
    offer_item(ActTick, 8'h00, 1'b0);
    offer_item(ActRxByte, ByteD, 1'b0);
    offer_item(ActRxByte, ByteStart, 1'b0);
    offer_item(ActImage, 8'h12, 1'b0);
    offer_item(ActTick, 8'h00, 1'b0);
    repeat (4) offer_item(ActRxErr, 8'h80, 1'b0);

    // random part, one register setting per phase
    phase_no  = 0;
    rand_base = item_total;
    while (item_total - rand_base < 420) begin
      case (phase_no)
        0:       load_registers(3, 4, 2, 3, 6);
        1:       load_registers(0, 0, 0, 1, 1);
        2:       load_registers(1, 65535, 65535, 7, 63);
        default: load_registers($urandom_range(0, 8), $urandom_range(0, 6),
                                $urandom_range(0, 6), $urandom_range(1, 7),
                                $urandom_range(1, 10));
      endcase
      // one phase runs flat out on both sides
      jitter_on = (phase_no != 3);
      if (phase_no == 0) hold_asks++;
      phase_base = item_total;
      while (item_total - phase_base < 70) begin
        if ($urandom_range(0, 99) < 8) stray_items();
        else run_download();
      end
      phase_no++;
    end

    // drain, then wait for anything that should not come
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    spins = 0;
    while (backlog != 0 && spins < 20000) begin
      @(posedge clk_i);
      spins++;
    end
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && backlog == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/ubil_pkg.sv
sv/ubil_core.sv
sv/ubil_outq.sv
sv/uart_boot_image_loader.sv
tb/ubil_download_checker.sv
tb/uart_boot_image_loader_test.sv
